### hw/rtl/pcm_pkg.sv
package pcm_pkg;

  // coordinate frame defaults
  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 1024;

  // field widths
  localparam int unsigned CoordW = 10;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned ProdW  = 43;  // 32 signed x 11 signed
  localparam int unsigned SumW   = 45;  // three products, signed
  localparam int unsigned QuoW   = 33;  // quotient bits kept before saturation
  localparam int unsigned FracW  = 16;

  // register indexes
  localparam logic [2:0] CfgH00H01 = 3'd0;
  localparam logic [2:0] CfgH02H10 = 3'd1;
  localparam logic [2:0] CfgH11H12 = 3'd2;
  localparam logic [2:0] CfgH20H21 = 3'd3;
  localparam logic [2:0] CfgH22    = 3'd4;

  // data that travels beside the dividers
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        ovf_x;
    logic        ovf_y;
    logic        w_zero;
    logic [31:0] sat_x;
    logic [31:0] sat_y;
  } side_t;

endpackage

### hw/rtl/perspective_coordinate_mapper.sv
// channel   dir  fields (lsb first)                              handshake
// s_axis    in   tdata: dst_x[9:0], dst_y[19:10], zero pad       tvalid/tready
// m_axis    out  tdata: src_x[31:0], src_y[63:32]; tuser: w_zero tvalid/tready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                 write only
//
// one transaction per cycle sustained unless m_axis stalls; the multiply, sum
// and sign stages feed the 33 one-bit stages of the two restoring dividers
// reset clears only the valid bits and loads the identity matrix
// a stall at m_axis freezes the whole pipeline with one shared enable,
// bubbles included; input is taken whenever the output register is empty
// or its transaction completes in the same cycle
module perspective_coordinate_mapper #(
  parameter int unsigned MAX_COLS = pcm_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = pcm_pkg::MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // dst_x, dst_y, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // src_x, src_y
  output logic        m_axis_tuser,   // w_zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned SW = pcm_pkg::SumW;
  localparam int unsigned PW = pcm_pkg::ProdW;
  localparam int unsigned QW = pcm_pkg::QuoW;
  localparam int unsigned FW = pcm_pkg::FracW;
  localparam int unsigned CW = pcm_pkg::CoordW;
  localparam logic [12:0] ColMax = 13'(MAX_COLS - 1);
  localparam logic [12:0] RowMax = 13'(MAX_ROWS - 1);

  // coefficient registers
  logic [63:0] c0_q, c1_q, c2_q, c3_q;
  logic [31:0] c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= 64'd65536;
      c1_q <= '0;
      c2_q <= 64'd65536;
      c3_q <= '0;
      c4_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcm_pkg::CfgH00H01: c0_q <= cfg_data_i;
        pcm_pkg::CfgH02H10: c1_q <= cfg_data_i;
        pcm_pkg::CfgH11H12: c2_q <= cfg_data_i;
        pcm_pkg::CfgH20H21: c3_q <= cfg_data_i;
        pcm_pkg::CfgH22:    c4_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // shared pipeline enable
  logic en;
  logic out_valid_q;
  assign en            = m_axis_tready | ~out_valid_q;
  assign s_axis_tready = en;

  // stage 1: clamp and multiply
  logic [CW-1:0] xin, yin, xc, yc;
  assign xin = s_axis_tdata[CW-1:0];
  assign yin = s_axis_tdata[2*CW-1:CW];
  assign xc  = ({3'b0, xin} > ColMax) ? ColMax[CW-1:0] : xin;
  assign yc  = ({3'b0, yin} > RowMax) ? RowMax[CW-1:0] : yin;

  logic signed [CW:0] xs, ys;
  assign xs = signed'({1'b0, xc});
  assign ys = signed'({1'b0, yc});

  logic          v1_q;
  logic [PW-1:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q;
  logic [31:0]   h02_q, h12_q, h22_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_q <= PW'(signed'(c0_q[31:0])  * xs);
      p01_q <= PW'(signed'(c0_q[63:32]) * ys);
      p10_q <= PW'(signed'(c1_q[63:32]) * xs);
      p11_q <= PW'(signed'(c2_q[31:0])  * ys);
      p20_q <= PW'(signed'(c3_q[31:0])  * xs);
      p21_q <= PW'(signed'(c3_q[63:32]) * ys);
      h02_q <= c1_q[31:0];
      h12_q <= c2_q[63:32];
      h22_q <= c4_q;
    end
  end

  // stage 2: homogeneous sums
  logic          v2_q;
  logic [SW-1:0] xh_q, yh_q, wh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xh_q <= {{2{p00_q[PW-1]}}, p00_q} + {{2{p01_q[PW-1]}}, p01_q}
            + {{13{h02_q[31]}}, h02_q};
      yh_q <= {{2{p10_q[PW-1]}}, p10_q} + {{2{p11_q[PW-1]}}, p11_q}
            + {{13{h12_q[31]}}, h12_q};
      wh_q <= {{2{p20_q[PW-1]}}, p20_q} + {{2{p21_q[PW-1]}}, p21_q}
            + {{13{h22_q[31]}}, h22_q};
    end
  end

  // stage 3: magnitudes, signs, plain saturation for the zero divisor case
  function automatic logic [31:0] sat32(input logic [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:31] == '0) || (v[SW-1:31] == '1);
    if (fits) return v[31:0];
    return v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  logic          v3_q;
  logic [SW-1:0] nx_q, ny_q, dd_q;
  logic          negx_q, negy_q, wz_q;
  logic [31:0]   satx_q, saty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= xh_q[SW-1] ? -xh_q : xh_q;
      ny_q   <= yh_q[SW-1] ? -yh_q : yh_q;
      dd_q   <= wh_q[SW-1] ? -wh_q : wh_q;
      negx_q <= xh_q[SW-1] ^ wh_q[SW-1];
      negy_q <= yh_q[SW-1] ^ wh_q[SW-1];
      wz_q   <= (wh_q == '0);
      satx_q <= sat32(xh_q);
      saty_q <= sat32(yh_q);
    end
  end

  // quotient needs more than QW bits when n >= d << (QW - FW)
  pcm_pkg::side_t side_d;
  always_comb begin
    side_d.neg_x  = negx_q;
    side_d.neg_y  = negy_q;
    side_d.w_zero = wz_q;
    side_d.sat_x  = satx_q;
    side_d.sat_y  = saty_q;
    side_d.ovf_x  = {{(QW-FW){1'b0}}, nx_q} >= {dd_q, {(QW-FW){1'b0}}};
    side_d.ovf_y  = {{(QW-FW){1'b0}}, ny_q} >= {dd_q, {(QW-FW){1'b0}}};
  end

  // dividers: (n << FW) / d, the first remainder is (n << FW) >> QW
  logic [QW-1:0] qx, qy;

  pcm_divider #(.NumW(SW), .QW(QW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ({{(QW-FW){1'b0}}, nx_q[SW-1:QW-FW]}),
    .low_i ({nx_q[QW-FW-1:0], {FW{1'b0}}}),
    .den_i (dd_q),
    .quo_o (qx)
  );

  pcm_divider #(.NumW(SW), .QW(QW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ({{(QW-FW){1'b0}}, ny_q[SW-1:QW-FW]}),
    .low_i ({ny_q[QW-FW-1:0], {FW{1'b0}}}),
    .den_i (dd_q),
    .quo_o (qy)
  );

  // side data and valid bits delayed alongside the divider stages
  logic [QW-1:0]  vd_q;
  pcm_pkg::side_t side_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= '0;
    else if (en) vd_q <= {vd_q[QW-2:0], v3_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < QW; i++) side_q[i] <= side_q[i-1];
    end
  end

  // final stage: sign and quotient saturation
  function automatic logic [31:0] fix_q(input logic [QW-1:0] q, input logic neg,
                                        input logic ovf);
    logic [QW-1:0] nq;
    nq = -q;
    if (neg) begin
      if (ovf || q > QW'(33'h0_8000_0000)) return 32'h8000_0000;
      return nq[31:0];
    end
    if (ovf || q > QW'(33'h0_7FFF_FFFF)) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  pcm_pkg::side_t sl;
  assign sl = side_q[QW-1];

  logic [31:0] srcx_q, srcy_q;
  logic        wzo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vd_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srcx_q <= sl.w_zero ? sl.sat_x : fix_q(qx, sl.neg_x, sl.ovf_x);
      srcy_q <= sl.w_zero ? sl.sat_y : fix_q(qy, sl.neg_y, sl.ovf_y);
      wzo_q  <= sl.w_zero;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {srcy_q, srcx_q};
  assign m_axis_tuser  = wzo_q;

`ifndef SYNTHESIS
  // a zero divisor always looks like quotient overflow to the divider entry
  a_wz_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && wz_q |-> side_d.ovf_x && side_d.ovf_y)
    else $error("zero divisor without overflow flags");

  // a held result stays valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q)
    else $error("result dropped under stall");

  // an accepted input shows up in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted input lost");

  // the last divider slot feeds the output exactly when enabled
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vd_q[QW-1] |=> out_valid_q)
    else $error("divider result lost");
`endif

endmodule

### hw/rtl/pcm_divider.sv
module pcm_divider #(
  parameter int unsigned NumW = pcm_pkg::SumW,
  parameter int unsigned QW   = pcm_pkg::QuoW
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] rem_i,
  input  logic [QW-1:0]   low_i,
  input  logic [NumW-1:0] den_i,
  output logic [QW-1:0]   quo_o
);

  logic [NumW-1:0] rem_q [QW];
  logic [QW-1:0]   low_q [QW];
  logic [NumW-1:0] den_q [QW];
  logic [QW-1:0]   quo_q [QW];

  // one restoring step per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NumW-1:0] rem_in;
    logic [QW-1:0]   low_in;
    logic [NumW-1:0] den_in;
    logic [QW-1:0]   quo_in;
    logic [NumW:0]   trial;
    logic [NumW:0]   diff;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[NumW-1:0] : trial[NumW-1:0];
        low_q[k] <= {low_in[QW-2:0], 1'b0};
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QW-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
